// ----- rtl/brf_pkg.sv -----
// Shared types and constants for the byte ring buffer with delimited read.
// No dependencies; used by the interfaces, all modules and the checker.
package brf_pkg;

  localparam int unsigned DepthDef = 64;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned FillW    = 6;
  localparam int unsigned ModeW    = 2;

  localparam logic [SizeW-1:0] SizeReset = 7'd64;

  // Input mode codes as seen on the port
  localparam logic [ModeW-1:0] ModeInsert = 2'd0;
  localparam logic [ModeW-1:0] ModeGet    = 2'd1;
  localparam logic [ModeW-1:0] ModeRead   = 2'd2;
  localparam logic [ModeW-1:0] ModeClear  = 2'd3;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_GET,
    OP_READ,
    OP_CLEAR
  } op_e;

  // Classified command handed from front to back
  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] delim;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0] data_out;
    logic             ok;
    logic             last;
    logic [FillW-1:0] fill_count;
    logic             is_full;
    logic [ByteW-1:0] last_inserted;
  } res_t;

endpackage

// ----- rtl/brf_item_if.sv -----
// Input channel of the byte ring buffer: valid/ready plus one operation.
// Depends on brf_pkg for field widths.
interface brf_item_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::ModeW-1:0]   mode;
  logic [brf_pkg::ByteW-1:0]   data_in;
  logic [brf_pkg::ByteW-1:0]   delimiter;

  modport source (output valid, mode, data_in, delimiter, input ready);
  modport sink   (input valid, mode, data_in, delimiter, output ready);
endinterface

// ----- rtl/brf_result_if.sv -----
// Result channel of the byte ring buffer: valid/ready plus one result item.
// Depends on brf_pkg for field widths.
interface brf_result_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::ByteW-1:0]   data_out;
  logic                        ok;
  logic                        last;
  logic [brf_pkg::FillW-1:0]   fill_count;
  logic                        is_full;
  logic [brf_pkg::ByteW-1:0]   last_inserted;

  modport source (output valid, data_out, ok, last, fill_count, is_full, last_inserted,
                  input ready);
  modport sink   (input valid, data_out, ok, last, fill_count, is_full, last_inserted,
                  output ready);
endinterface

// ----- rtl/brf_front.sv -----
// Front end: accepts input transfers, decodes the mode into an operation
// and holds up to two commands for the back end. Depends on brf_pkg.
module brf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [brf_pkg::ModeW-1:0] mode_i,
  input  logic [brf_pkg::ByteW-1:0] data_i,
  input  logic [brf_pkg::ByteW-1:0] delim_i,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i,
  output brf_pkg::cmd_t cmd_o
);

  brf_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q, cnt_d;
  brf_pkg::cmd_t new_cmd;
  logic          push, pop;

  // Decode the mode into an operation
  always_comb begin
    new_cmd.data  = data_i;
    new_cmd.delim = delim_i;
    unique case (mode_i)
      brf_pkg::ModeInsert: new_cmd.op = brf_pkg::OP_INSERT;
      brf_pkg::ModeGet:    new_cmd.op = brf_pkg::OP_GET;
      brf_pkg::ModeRead:   new_cmd.op = brf_pkg::OP_READ;
      default:             new_cmd.op = brf_pkg::OP_CLEAR;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  // Queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

// ----- rtl/brf_back.sv -----
// Back end: owns the byte store, the head/tail pointers and the count,
// carries out commands and drives the registered result. Depends on brf_pkg.
module brf_back #(
  parameter int unsigned DEPTH = brf_pkg::DepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [brf_pkg::SizeW-1:0] cfg_data_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  brf_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output brf_pkg::res_t res_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [brf_pkg::SizeW-1:0] DepthS = brf_pkg::SizeW'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_TERM = 2'd2;

  // Byte store with per-entry valid bits (unwritten entries read as zero)
  logic [brf_pkg::ByteW-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]          vld_q;
  logic [brf_pkg::ByteW-1:0] rdata_q;
  logic                      rvld_q;

  logic [1:0]                state_q, state_d;
  logic [PW-1:0]             head_q, head_d, tail_q, tail_d;
  logic [brf_pkg::FillW-1:0] cnt_q, cnt_d;
  logic [brf_pkg::SizeW-1:0] size_q, slots;
  logic [brf_pkg::ByteW-1:0] hbyte_q, hbyte_d, ent0_q;
  brf_pkg::op_e              op_q, op_d;
  logic [brf_pkg::ByteW-1:0] delim_q, delim_d;

  logic                      out_vld_q, out_free, load;
  brf_pkg::res_t             res_q, res_d;
  logic                      we, re;
  logic [PW-1:0]             waddr, nh;
  logic [brf_pkg::ByteW-1:0] rbyte;
  logic                      full_now;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] idx,
                                        input logic [brf_pkg::SizeW-1:0] sl);
    logic [brf_pkg::SizeW-1:0] n;
    n = brf_pkg::SizeW'(idx) + 1'b1;
    return (n >= sl) ? '0 : n[PW-1:0];
  endfunction

  // Slot count saturated to [2, DEPTH]
  always_comb begin
    if (size_q < 7'd2) begin
      slots = 7'd2;
    end else if (size_q > DepthS) begin
      slots = DepthS;
    end else begin
      slots = size_q;
    end
  end

  assign nh       = adv(head_q, slots);
  assign full_now = (nh == tail_q);
  assign out_free = !out_vld_q || res_ready_i;
  assign rbyte    = rvld_q ? rdata_q : '0;
  assign waddr    = nh;

  // Command sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    hbyte_d   = hbyte_q;
    op_d      = op_q;
    delim_d   = delim_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    load      = 1'b0;
    res_d.data_out      = '0;
    res_d.ok            = 1'b1;
    res_d.last          = 1'b1;
    res_d.fill_count    = cnt_q;
    res_d.is_full       = full_now;
    res_d.last_inserted = hbyte_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          delim_d   = cmd_i.delim;
          case (cmd_i.op) inside
            brf_pkg::OP_INSERT: begin
              load = 1'b1;
              if (full_now) begin
                res_d.ok = 1'b0;
              end else begin
                we      = 1'b1;
                head_d  = nh;
                cnt_d   = cnt_q + 1'b1;
                hbyte_d = cmd_i.data;
                res_d.fill_count    = cnt_d;
                res_d.is_full       = (adv(nh, slots) == tail_q);
                res_d.last_inserted = cmd_i.data;
              end
            end
            brf_pkg::OP_GET, brf_pkg::OP_READ: begin
              if (head_q == tail_q) begin
                load     = 1'b1;
                res_d.ok = (cmd_i.op == brf_pkg::OP_READ);
              end else begin
                re      = 1'b1;
                tail_d  = adv(tail_q, slots);
                cnt_d   = cnt_q - 1'b1;
                state_d = ST_POP;
              end
            end
            default: begin
              load    = 1'b1;
              head_d  = '0;
              tail_d  = '0;
              cnt_d   = '0;
              hbyte_d = ent0_q;
              res_d.fill_count    = '0;
              res_d.is_full       = 1'b0;
              res_d.last_inserted = ent0_q;
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          load = 1'b1;
          if (op_q == brf_pkg::OP_GET) begin
            res_d.data_out = rbyte;
            state_d        = ST_IDLE;
          end else if (rbyte == delim_q) begin
            // delimiter dropped, terminator in its place
            state_d = ST_IDLE;
          end else begin
            res_d.data_out = rbyte;
            res_d.last     = 1'b0;
            if (head_q != tail_q) begin
              re     = 1'b1;
              tail_d = adv(tail_q, slots);
              cnt_d  = cnt_q - 1'b1;
            end else begin
              state_d = ST_TERM;
            end
          end
        end
      end
      ST_TERM: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Size write re-initialises the pointers
    if (cfg_we_i) begin
      head_d  = '0;
      tail_d  = '0;
      cnt_d   = '0;
      hbyte_d = ent0_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      size_q    <= brf_pkg::SizeReset;
      hbyte_q   <= '0;
      ent0_q    <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      hbyte_q <= hbyte_d;
      if (cfg_we_i) size_q <= cfg_data_i;
      if (we) begin
        vld_q[waddr] <= 1'b1;
        if (waddr == '0) ent0_q <= cmd_i.data;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Store write and registered read at the new tail
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= cmd_i.data;
    end
    if (re) begin
      rdata_q <= mem_q[tail_d];
      rvld_q  <= vld_q[tail_d];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
    op_q    <= op_d;
    delim_q <= delim_d;
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/byte_ring_fifo_with_delimited_read.sv -----
// Top level of the byte ring buffer with delimited read.
// Depends on brf_pkg, brf_item_if, brf_result_if, brf_front and brf_back.
// Use:
//   item_i carries one operation per transfer: insert, get, delimited read or
//   clear. result_o returns the results in order; every operation ends with a
//   result marked last. cfg_we_i/cfg_data_i write the slot count in use (the
//   buffer holds one byte less) and reset the pointers; write only when idle.
// Flow:
//   An accepted item waits in a two-entry command queue. Insert, clear and a
//   get or read on an empty buffer go through the queue and the output
//   register, one item per cycle unless result_o.ready stalls. A get that
//   pops adds the registered store read. A delimited read sends its bytes,
//   one per cycle unless stalled, then the terminator; a read that drains
//   the buffer sends the terminator from a separate state.
// Reset:
//   Pointers and count go to zero, the slot count to 64; store entries read
//   as zero until written (per-entry valid bits, no sweep).
// Stall:
//   A result waits in the output register while result_o.ready is low; the
//   command queue keeps taking items until it fills, then item_i.ready drops.
module byte_ring_fifo_with_delimited_read #(
  parameter int unsigned DEPTH = brf_pkg::DepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [brf_pkg::SizeW-1:0]  cfg_data_i,
  brf_item_if.sink                   item_i,
  brf_result_if.source               result_o
);

  logic          cmd_valid, cmd_pop;
  brf_pkg::cmd_t cmd;
  brf_pkg::res_t res;

  // Front: accept and decode
  brf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .mode_i     (item_i.mode),
    .data_i     (item_i.data_in),
    .delim_i    (item_i.delimiter),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd)
  );

  // Back: store, pointers and results
  brf_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd),
    .res_valid_o(result_o.valid),
    .res_ready_i(result_o.ready),
    .res_o      (res)
  );

  assign result_o.data_out      = res.data_out;
  assign result_o.ok            = res.ok;
  assign result_o.last          = res.last;
  assign result_o.fill_count    = res.fill_count;
  assign result_o.is_full       = res.is_full;
  assign result_o.last_inserted = res.last_inserted;

endmodule

// ----- rtl/brf_checker.sv -----
// Port-level checks on the result channel of the byte ring buffer, and the
// bind that attaches them to the top level. Depends on brf_pkg.
module brf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       valid_i,
  input logic                       ready_i,
  input logic [brf_pkg::ByteW-1:0]  data_out_i,
  input logic                       ok_i,
  input logic                       last_i,
  input logic [brf_pkg::FillW-1:0]  fill_count_i,
  input logic                       is_full_i
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(data_out_i) && $stable(last_i))
    else $error("result changed while stalled");

  // A refused operation gives one zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ok_i |-> last_i && (data_out_i == '0))
    else $error("refused result not a single zero result");

  // Only delimited reads give non-final results, and they always succeed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !last_i |-> ok_i)
    else $error("non-final result not ok");

  // An empty buffer is never full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (fill_count_i == '0) |-> !is_full_i)
    else $error("empty buffer reported full");

endmodule

bind byte_ring_fifo_with_delimited_read brf_checker u_brf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .valid_i     (result_o.valid),
  .ready_i     (result_o.ready),
  .data_out_i  (result_o.data_out),
  .ok_i        (result_o.ok),
  .last_i      (result_o.last),
  .fill_count_i(result_o.fill_count),
  .is_full_i   (result_o.is_full)
);
